FILE: rtl/bmprle8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle8_pkg
// Shared types and constants of the BMP RLE8 stream decoder.
// ----------------------------------------------------------------------------
package bmprle8_pkg;

    localparam int unsigned MAX_DIMENSION_DEF = 4096;

    localparam int unsigned DIM_REG_W = 13;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ROW_OUT_W = 12;
    localparam int unsigned COL_OUT_W = 12;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_SPAN     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED   = 2'd3;

    typedef enum logic [3:0] {
        PH_COUNT   = 4'd0,
        PH_VALUE   = 4'd1,
        PH_ESCAPE  = 4'd2,
        PH_LITERAL = 4'd3,
        PH_PAD     = 4'd4,
        PH_EOL1    = 4'd5,
        PH_EOL2    = 4'd6,
        PH_END1    = 4'd7,
        PH_END2    = 4'd8,
        PH_DONE    = 4'd9,
        PH_ERROR   = 4'd10
    } t_phase;

endpackage

FILE: rtl/bmp_rle8_decoder_unit.sv
`timescale 1ns / 1ps
// A byte passes the input register, then the result register; the phase/column/row update
// is combinational between them. Throughput: one stream byte per cycle while the result
// port is not stalled. A byte that yields no result produces no output transaction.
// Reset (synchronous, active low): decoder state clears to "expect run count", both
// pipeline registers empty, image width and height return to 1.
// ----------------------------------------------------------------------------
// bmp_rle8_decoder_unit
// BMP RLE8 stream decoder: one compressed byte in, at most one pixel span,
// image-complete mark or format error out.
// ----------------------------------------------------------------------------
module bmp_rle8_decoder_unit
    import bmprle8_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DIM_REG_W-1:0]  i_cfg_data,
    // byte input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_end_of_data,
    input  logic                  i_start_image,
    // result output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ROW_OUT_W-1:0]  o_row_index,
    output logic [COL_OUT_W-1:0]  o_column_start,
    output logic [BYTE_W-1:0]     o_span_length,
    output logic [BYTE_W-1:0]     o_pixel_value,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int unsigned ROW_W = $clog2(MAX_DIMENSION);
    localparam int unsigned CW    = ((DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W) + 1;
    localparam logic [CW-1:0] MAX_DIM_C = CW'(MAX_DIMENSION);

    // configuration registers
    logic [DIM_REG_W-1:0] r_image_width;
    logic [DIM_REG_W-1:0] r_image_height;

    // input register
    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_data_byte;
    logic                 r_end_of_data;
    logic                 r_start_image;

    // decoder state
    t_phase               r_phase,        n_phase;
    logic [DIM_W-1:0]     r_column,       n_column;
    logic [ROW_W-1:0]     r_stream_row,   n_stream_row;
    logic [BYTE_W-1:0]    r_run_count,    n_run_count;
    logic [BYTE_W-1:0]    r_literal_left, n_literal_left;
    logic                 r_literal_odd,  n_literal_odd;

    // result register
    logic                 r_out_valid,    n_out_valid;
    logic [ROW_OUT_W-1:0] r_row_index,    n_row_index;
    logic [COL_OUT_W-1:0] r_column_start, n_column_start;
    logic [BYTE_W-1:0]    r_span_length,  n_span_length;
    logic [BYTE_W-1:0]    r_pixel_value,  n_pixel_value;
    logic [STATUS_W-1:0]  r_status,       n_status;

    logic advance;
    logic process;

    // The input register drains whenever the result slot is free or being taken.
    assign advance     = !r_out_valid || !i_out_stall;
    assign process     = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_REG_W'(1);
            r_image_height <= DIM_REG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_data_byte   <= i_data_byte;
            r_end_of_data <= i_end_of_data;
            r_start_image <= i_start_image;
        end
    end

    // ------------------------------------------------------------------
    // Decode step
    // ------------------------------------------------------------------
    logic [CW-1:0]     w_eff;
    logic [CW-1:0]     h_eff;
    t_phase            ph0;
    logic [DIM_W-1:0]  col0;
    logic [ROW_W-1:0]  row0;
    logic [BYTE_W-1:0] run0;
    logic [BYTE_W-1:0] lit_left0;
    logic              lit_odd0;
    logic [CW-1:0]     col_c;
    logic [CW-1:0]     row_c;
    logic [CW-1:0]     byte_c;
    logic [CW-1:0]     col_plus_byte;
    logic [CW-1:0]     row_out;
    logic              last_row;
    logic              stopped;
    logic              fail;
    logic              complete;
    logic              span;
    logic [BYTE_W-1:0] span_len;
    logic [BYTE_W-1:0] lit_dec;

    always_comb begin
        w_eff = (CW'(r_image_width) > MAX_DIM_C) ? MAX_DIM_C : CW'(r_image_width);
        h_eff = (CW'(r_image_height) > MAX_DIM_C) ? MAX_DIM_C : CW'(r_image_height);

        // start of a new image clears the state ahead of this byte
        if (r_start_image) begin
            ph0       = PH_COUNT;
            col0      = '0;
            row0      = '0;
            run0      = '0;
            lit_left0 = '0;
            lit_odd0  = 1'b0;
        end else begin
            ph0       = r_phase;
            col0      = r_column;
            row0      = r_stream_row;
            run0      = r_run_count;
            lit_left0 = r_literal_left;
            lit_odd0  = r_literal_odd;
        end

        col_c         = CW'(col0);
        row_c         = CW'(row0);
        byte_c        = CW'(r_data_byte);
        col_plus_byte = col_c + byte_c;
        row_out       = h_eff - CW'(1) - row_c;
        last_row      = (row_c + CW'(1)) >= h_eff;
        stopped       = (ph0 == PH_DONE) || (ph0 == PH_ERROR);
        lit_dec       = lit_left0 - BYTE_W'(1);

        // a filled row or a finished image redirects the count phase
        if (ph0 == PH_COUNT) begin
            if (row_c >= h_eff) begin
                ph0 = PH_END1;
            end else if (col_c >= w_eff) begin
                ph0 = PH_EOL1;
            end
        end

        n_phase        = ph0;
        n_column       = col0;
        n_stream_row   = row0;
        n_run_count    = run0;
        n_literal_left = lit_left0;
        n_literal_odd  = lit_odd0;
        fail           = 1'b0;
        complete       = 1'b0;
        span           = 1'b0;
        span_len       = '0;

        unique case (ph0)
            PH_COUNT: begin
                if (r_data_byte == '0) begin
                    n_phase = PH_ESCAPE;
                end else if (col_plus_byte > w_eff) begin
                    fail = 1'b1;
                end else begin
                    n_run_count = r_data_byte;
                    n_phase     = PH_VALUE;
                end
            end
            PH_VALUE: begin
                span     = 1'b1;
                span_len = run0;
                n_column = col0 + DIM_W'(run0);
                n_phase  = PH_COUNT;
            end
            PH_ESCAPE: begin
                if (r_data_byte <= BYTE_W'(2) || col_plus_byte > w_eff) begin
                    fail = 1'b1;
                end else begin
                    n_literal_left = r_data_byte;
                    n_literal_odd  = r_data_byte[0];
                    n_phase        = PH_LITERAL;
                end
            end
            PH_LITERAL: begin
                span           = 1'b1;
                span_len       = BYTE_W'(1);
                n_column       = col0 + DIM_W'(1);
                n_literal_left = lit_dec;
                if (lit_dec == '0) begin
                    n_phase = lit_odd0 ? PH_PAD : PH_COUNT;
                end
            end
            PH_PAD: begin
                n_phase = PH_COUNT;
            end
            PH_EOL1: begin
                if (r_data_byte == '0) begin
                    n_phase = PH_EOL2;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_EOL2: begin
                if (r_data_byte == '0) begin
                    if (last_row) begin
                        n_phase = PH_END1;
                    end else begin
                        n_stream_row = row0 + ROW_W'(1);
                        n_column     = '0;
                        n_phase      = PH_COUNT;
                    end
                end else if (r_data_byte == BYTE_W'(1) && last_row) begin
                    complete = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_END1: begin
                if (r_data_byte == '0) begin
                    n_phase = PH_END2;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_END2: begin
                if (r_data_byte == BYTE_W'(1)) begin
                    complete = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end
            default: begin
                fail = 1'b1;
            end
        endcase

        n_out_valid    = 1'b1;
        n_row_index    = '0;
        n_column_start = '0;
        n_span_length  = '0;
        n_pixel_value  = '0;
        n_status       = ST_SPAN;

        priority if (stopped) begin
            // hold everything after the end mark or an error
            n_phase        = ph0;
            n_column       = col0;
            n_stream_row   = row0;
            n_run_count    = run0;
            n_literal_left = lit_left0;
            n_literal_odd  = lit_odd0;
            n_out_valid    = 1'b0;
        end else if (complete) begin
            n_phase  = PH_DONE;
            n_status = ST_COMPLETE;
        end else if (fail || r_end_of_data) begin
            n_phase  = PH_ERROR;
            n_status = ST_ERROR;
        end else if (span) begin
            n_row_index    = row_out[ROW_OUT_W-1:0];
            n_column_start = col_c[COL_OUT_W-1:0];
            n_span_length  = span_len;
            n_pixel_value  = r_data_byte;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_COUNT;
            r_column       <= '0;
            r_stream_row   <= '0;
            r_run_count    <= '0;
            r_literal_left <= '0;
            r_literal_odd  <= 1'b0;
        end else if (process) begin
            r_phase        <= n_phase;
            r_column       <= n_column;
            r_stream_row   <= n_stream_row;
            r_run_count    <= n_run_count;
            r_literal_left <= n_literal_left;
            r_literal_odd  <= n_literal_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && n_out_valid) begin
            r_row_index    <= n_row_index;
            r_column_start <= n_column_start;
            r_span_length  <= n_span_length;
            r_pixel_value  <= n_pixel_value;
            r_status       <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_index    = r_row_index;
    assign o_column_start = r_column_start;
    assign o_span_length  = r_span_length;
    assign o_pixel_value  = r_pixel_value;
    assign o_status       = r_status;

endmodule

FILE: rtl/bmprle8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle8_checker
// Port-level checks on the result channel of the RLE8 decoder.
// ----------------------------------------------------------------------------
module bmprle8_checker
    import bmprle8_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [ROW_OUT_W-1:0] o_row_index,
    input logic [COL_OUT_W-1:0] o_column_start,
    input logic [BYTE_W-1:0]    o_span_length,
    input logic [BYTE_W-1:0]    o_pixel_value,
    input logic [STATUS_W-1:0]  o_status
);

    // hold a stalled result
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_row_index) && $stable(o_column_start)
            && $stable(o_span_length) && $stable(o_pixel_value))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != ST_UNUSED)
        else $error("undefined status code");

    a_mark_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_SPAN |-> o_row_index == '0
            && o_column_start == '0 && o_span_length == '0 && o_pixel_value == '0)
        else $error("completion or error mark carries span fields");

    a_span_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_SPAN |-> o_span_length != '0)
        else $error("empty pixel span");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind bmp_rle8_decoder_unit bmprle8_checker u_bmprle8_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_row_index    (o_row_index),
    .o_column_start (o_column_start),
    .o_span_length  (o_span_length),
    .o_pixel_value  (o_pixel_value),
    .o_status       (o_status)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BMP RLE8 stream decoder. Feeds whole encoded
// images, some of them damaged, one byte per transaction, predicts every
// span, completion mark and format error, and checks them in order at the
// result port under random idling and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import bmprle8_pkg::*;

    localparam int unsigned TAIL_CYCLES = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_data;
        logic              start_image;
        logic              drain_first;   // hold off until all results are in
    } t_rle_byte;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row_index;
        logic [COL_OUT_W-1:0] column_start;
        logic [BYTE_W-1:0]    span_length;
        logic [BYTE_W-1:0]    pixel_value;
        logic [STATUS_W-1:0]  status;
    } t_span;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_REG_W-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 i_end_of_data = 1'b0;
    logic                 i_start_image = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [ROW_OUT_W-1:0] o_row_index;
    logic [COL_OUT_W-1:0] o_column_start;
    logic [BYTE_W-1:0]    o_span_length;
    logic [BYTE_W-1:0]    o_pixel_value;
    logic [STATUS_W-1:0]  o_status;

    bmp_rle8_decoder_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_data  (i_end_of_data),
        .i_start_image  (i_start_image),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_row_index    (o_row_index),
        .o_column_start (o_column_start),
        .o_span_length  (o_span_length),
        .o_pixel_value  (o_pixel_value),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_rle_byte   stream_bytes[$];
    t_span       predicted_spans[$];
    t_rle_byte   byte_on_bus;

    int unsigned send_gap_pct = 24;
    int unsigned recv_stall_pct = 54;
    int unsigned mismatch_count = 0;
    int unsigned bytes_accepted = 0;
    int unsigned spans_seen = 0;
    int unsigned images_seen = 0;
    int unsigned errors_seen = 0;
    int unsigned settings_run = 0;

    // Decoder shadow: dimension registers and stream position
    int unsigned cfg_width = 1;
    int unsigned cfg_height = 1;
    t_phase      dec_phase = PH_COUNT;
    logic [12:0] dec_col = '0;
    logic [11:0] dec_row = '0;
    logic [7:0]  dec_run = '0;
    logic [7:0]  dec_lit_left = '0;
    logic        dec_lit_odd = 1'b0;

    function automatic void clear_decoder();
        dec_phase = PH_COUNT;
        dec_col = '0;
        dec_row = '0;
        dec_run = '0;
        dec_lit_left = '0;
        dec_lit_odd = 1'b0;
    endfunction

    // Advance the decoder by one byte and queue whatever result it yields.
    function automatic void decode_rle8_byte(input t_rle_byte it);
        int unsigned w, h, b, row_out;
        bit          last_row, fail, complete, emit;
        t_span       res;
        fail = 1'b0;
        complete = 1'b0;
        emit = 1'b0;
        res = '0;
        b = 32'(it.data_byte);
        if (it.start_image)
            clear_decoder();
        if (dec_phase == PH_DONE || dec_phase == PH_ERROR)
            return;
        w = (cfg_width > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : cfg_width;
        h = (cfg_height > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : cfg_height;
        // a full row or a full image turns the next byte into a marker byte
        if (dec_phase == PH_COUNT) begin
            if (dec_row >= h)
                dec_phase = PH_END1;
            else if (dec_col >= w)
                dec_phase = PH_EOL1;
        end
        row_out = h - 1 - dec_row;
        last_row = (dec_row + 1 >= h);

        case (dec_phase)
            PH_COUNT: begin
                if (b == 0)
                    dec_phase = PH_ESCAPE;
                else if (dec_col + b > w)
                    fail = 1'b1;
                else begin
                    dec_run = it.data_byte;
                    dec_phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                emit = 1'b1;
                res.column_start = dec_col[11:0];
                res.span_length = dec_run;
                res.pixel_value = it.data_byte;
                dec_col = dec_col + dec_run;
                dec_phase = PH_COUNT;
            end
            PH_ESCAPE: begin
                if (b <= 2 || dec_col + b > w)
                    fail = 1'b1;
                else begin
                    dec_lit_left = it.data_byte;
                    dec_lit_odd = it.data_byte[0];
                    dec_phase = PH_LITERAL;
                end
            end
            PH_LITERAL: begin
                emit = 1'b1;
                res.column_start = dec_col[11:0];
                res.span_length = 8'd1;
                res.pixel_value = it.data_byte;
                dec_col = dec_col + 13'd1;
                dec_lit_left = dec_lit_left - 8'd1;
                if (dec_lit_left == 0)
                    dec_phase = dec_lit_odd ? PH_PAD : PH_COUNT;
            end
            PH_PAD: begin
                dec_phase = PH_COUNT;
            end
            PH_EOL1: begin
                if (b == 0)
                    dec_phase = PH_EOL2;
                else
                    fail = 1'b1;
            end
            PH_EOL2: begin
                if (b == 0) begin
                    if (last_row)
                        dec_phase = PH_END1;
                    else begin
                        dec_row = dec_row + 12'd1;
                        dec_col = '0;
                        dec_phase = PH_COUNT;
                    end
                end else if (b == 1 && last_row)
                    complete = 1'b1;
                else
                    fail = 1'b1;
            end
            PH_END1: begin
                if (b == 0)
                    dec_phase = PH_END2;
                else
                    fail = 1'b1;
            end
            PH_END2: begin
                if (b == 1)
                    complete = 1'b1;
                else
                    fail = 1'b1;
            end
            default: fail = 1'b1;
        endcase

        if (complete) begin
            dec_phase = PH_DONE;
            res = '0;
            res.status = ST_COMPLETE;
        end else if (fail || it.end_of_data) begin
            dec_phase = PH_ERROR;
            res = '0;
            res.status = ST_ERROR;
        end else if (emit) begin
            res.row_index = row_out[11:0];
            res.status = ST_SPAN;
        end else
            return;
        predicted_spans.push_back(res);
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input bit eod, input bit start,
                                       input bit pause);
        stream_bytes.push_back('{data_byte: b, end_of_data: eod, start_image: start,
                                 drain_first: pause});
    endfunction

    function automatic t_rle_byte plain_byte(input logic [7:0] b);
        plain_byte = '{data_byte: b, end_of_data: 1'b0, start_image: 1'b0, drain_first: 1'b0};
    endfunction

    // Encode one random image of w x h, cut at cap bytes, maybe damage it, and
    // queue it. Returns the number of image bytes, trailing junk not counted.
    function automatic int unsigned add_image(input int unsigned w, input int unsigned h,
                                              input int unsigned cap, input bit pause);
        t_rle_byte   frame[$];
        int unsigned r, c, n, k, room, junk;
        for (r = 0; r < h && frame.size() < cap; r++) begin
            c = 0;
            while (c < w && frame.size() < cap) begin
                room = w - c;
                n = (room > 255) ? 255 : room;
                if (room >= 3 && $urandom_range(0, 2) == 0) begin
                    // keep most absolute runs short to save bytes
                    if (n > 9 && $urandom_range(0, 7) != 0)
                        n = 9;
                    n = $urandom_range(3, n);
                    frame.push_back(plain_byte(8'h00));
                    frame.push_back(plain_byte(n[7:0]));
                    for (k = 0; k < n; k++)
                        frame.push_back(plain_byte(8'($urandom_range(0, 255))));
                    if (n[0])
                        frame.push_back(plain_byte(8'($urandom_range(0, 255))));
                end else begin
                    if ($urandom_range(0, 3) != 0)
                        n = $urandom_range(1, n);
                    frame.push_back(plain_byte(n[7:0]));
                    frame.push_back(plain_byte(8'($urandom_range(0, 255))));
                end
                c += n;
            end
            frame.push_back(plain_byte(8'h00));
            if (r + 1 < h || $urandom_range(0, 1) == 0)
                frame.push_back(plain_byte(8'h00));
            else
                frame.push_back(plain_byte(8'h01));   // last row may end on the marker
        end
        if (frame[frame.size() - 1].data_byte == 8'h00 && frame.size() < cap) begin
            frame.push_back(plain_byte(8'h00));
            frame.push_back(plain_byte(8'h01));
        end
        if ($urandom_range(0, 1) == 0)
            frame[frame.size() - 1].end_of_data = 1'b1;

        if ($urandom_range(0, 3) == 0 && frame.size() > 1) begin
            k = $urandom_range(1, frame.size() - 1);
            case ($urandom_range(0, 4))
                0: frame[k].data_byte = 8'($urandom_range(0, 255));
                1: frame[k].data_byte = 8'($urandom_range(0, 2));
                2: begin
                    frame[k].end_of_data = 1'b1;
                    while (frame.size() > k + 1)
                        void'(frame.pop_back());
                end
                3: frame.delete(k);
                default: frame[k].start_image = 1'b1;
            endcase
        end

        frame[0].start_image = 1'b1;
        frame[0].drain_first = pause;
        foreach (frame[i])
            stream_bytes.push_back(frame[i]);
        junk = $urandom_range(0, 2);
        for (k = 0; k < junk; k++)
            queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
        return frame.size();
    endfunction

    // Byte driver: hold the payload while stalled, pull the next transaction otherwise
    always @(posedge i_clk) begin : drive_bytes
        bit take_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take_next = !i_in_valid || !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                decode_rle8_byte(byte_on_bus);
                bytes_accepted++;
            end
            if (take_next) begin
                if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct
                        && !(stream_bytes[0].drain_first && predicted_spans.size() != 0)) begin
                    byte_on_bus = stream_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= byte_on_bus.data_byte;
                    i_end_of_data <= byte_on_bus.end_of_data;
                    i_start_image <= byte_on_bus.start_image;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic void report_mismatch(input string what, input t_span want,
                                            input t_span got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t %s: expected row %0d col %0d len %0d val %0d st %0d, ",
                     $realtime, what, want.row_index, want.column_start, want.span_length,
                     want.pixel_value, want.status,
                     "got row %0d col %0d len %0d val %0d st %0d",
                     got.row_index, got.column_start,
                     got.span_length, got.pixel_value, got.status);
    endfunction

    // Result monitor: compare each accepted transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_span got;
        t_span want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_row_index, o_column_start, o_span_length, o_pixel_value, o_status};
            case (got.status)
                ST_SPAN:     spans_seen++;
                ST_COMPLETE: images_seen++;
                default:     errors_seen++;
            endcase
            if (predicted_spans.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = predicted_spans.pop_front();
                if (got.row_index !== want.row_index
                        || got.column_start !== want.column_start
                        || got.span_length !== want.span_length
                        || got.pixel_value !== want.pixel_value
                        || got.status !== want.status)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // Drain everything in flight, then give bytes without results time to retire.
    task automatic wait_idle();
        while (stream_bytes.size() != 0 || i_in_valid || predicted_spans.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[DIM_REG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
    endtask

    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input int unsigned target, input int unsigned cap);
        int unsigned made;
        made = 0;
        wait_idle();
        write_dim(CFG_IMAGE_WIDTH, w);
        write_dim(CFG_IMAGE_HEIGHT, h);
        settings_run++;
        while (made < target)
            made += add_image(w, h, cap, $urandom_range(0, 9) == 0);
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed image set at 4 x 2
        wait_idle();
        write_dim(CFG_IMAGE_WIDTH, 4);
        write_dim(CFG_IMAGE_HEIGHT, 2);
        settings_run++;
        queue_byte(8'h04, 1'b0, 1'b1, 1'b0);   // full-width fill
        queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0, 1'b0);   // end of line
        queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0, 1'b0);   // odd absolute run, padded
        queue_byte(8'h03, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h7F, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0, 1'b0);   // end marker in place of the last end of line
        queue_byte(8'h01, 1'b0, 1'b0, 1'b0);
        queue_byte(8'hAA, 1'b1, 1'b0, 1'b0);   // ignored after completion
        queue_byte(8'h00, 1'b0, 1'b1, 1'b1);   // escape in mid-line
        queue_byte(8'h02, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h05, 1'b0, 1'b1, 1'b0);   // run past the row width
        queue_byte(8'h02, 1'b1, 1'b1, 1'b0);   // stream ends early
        queue_byte(8'h04, 1'b0, 1'b1, 1'b0);   // row not closed by end of line
        queue_byte(8'h11, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h07, 1'b0, 1'b0, 1'b0);

        run_phase(1, 1, 175, 200);
        run_phase($urandom_range(2, 24), $urandom_range(1, 5), 175, 200);

        send_gap_pct = 54;
        recv_stall_pct = 24;
        run_phase(4096, 2, 175, 350);
        run_phase(3, 4096, 175, 100);
        run_phase($urandom_range(1, 24), $urandom_range(1, 5), 175, 200);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        run_phase(4096, 4096, 150, 150);
        run_phase($urandom_range(1, 300), $urandom_range(1, 3), 175, 250);
        run_phase($urandom_range(1, 24), $urandom_range(1, 5), 175, 200);

        wait_idle();
        $display("Decoded %0d bytes over %0d image size settings: %0d spans, %0d images",
                 bytes_accepted, settings_run, spans_seen, images_seen);
        $display("completed, %0d format errors, %0d mismatches", errors_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Timed out with %0d bytes queued and %0d results outstanding",
                 stream_bytes.size(), predicted_spans.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bmprle8_pkg.sv
rtl/bmp_rle8_decoder_unit.sv
rtl/bmprle8_checker.sv
verif/testbench.sv
